/* hdl/u2c_pkg.sv */
// Shared types, constants and code tables for the UTF-8 to escaped CP1252 encoder.
`timescale 1ns / 1ps
package u2c_pkg;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [7:0]  ESC_BASE_RST  = 8'd16;
  localparam logic [15:0] OUT_LIMIT_RST = 16'h8000;

  localparam logic [7:0]  QMARK     = 8'h3F;
  localparam logic [7:0]  TERM_BYTE = 8'h00;

  localparam logic [15:0] PUA_LO     = 16'h0100;
  localparam logic [15:0] PUA_HI     = 16'h0A00;
  localparam logic [15:0] PUA_OFFSET = 16'hE000;
  localparam logic [7:0]  LOW_ADJ    = 8'd14;
  localparam logic [7:0]  HIGH_ADJ   = 8'd9;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ESCAPE_BASE = 1'b0,
    REG_OUT_LIMIT   = 1'b1
  } cfg_reg_t;

  // One queued unit: up to four body bytes (fourth and later read as '?') plus terminator.
  typedef struct packed {
    logic [2:0] cnt;
    logic       term;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } u2c_desc_t;

  function automatic logic is_esc(input logic [7:0] b);
    logic hit;
    case (b)
      8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
      8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'h5F, 8'hBD, 8'h3B,
      8'h5D, 8'h3D, 8'h23, 8'h3F, 8'h3A, 8'h3C, 8'h3E, 8'h2A, 8'h7C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // {hit, cp1252 byte} for the Windows-1252 specials in the 0x80..0x9F range
  function automatic logic [8:0] special_map(input logic [15:0] cp);
    logic [8:0] r;
    case (cp)
      16'h20AC: r = {1'b1, 8'h80};
      16'h201A: r = {1'b1, 8'h82};
      16'h0192: r = {1'b1, 8'h83};
      16'h201E: r = {1'b1, 8'h84};
      16'h2026: r = {1'b1, 8'h85};
      16'h2020: r = {1'b1, 8'h86};
      16'h2021: r = {1'b1, 8'h87};
      16'h02C6: r = {1'b1, 8'h88};
      16'h2030: r = {1'b1, 8'h89};
      16'h0160: r = {1'b1, 8'h8A};
      16'h2039: r = {1'b1, 8'h8B};
      16'h0152: r = {1'b1, 8'h8C};
      16'h017D: r = {1'b1, 8'h8E};
      16'h2018: r = {1'b1, 8'h91};
      16'h2019: r = {1'b1, 8'h92};
      16'h201C: r = {1'b1, 8'h93};
      16'h201D: r = {1'b1, 8'h94};
      16'h2022: r = {1'b1, 8'h95};
      16'h2013: r = {1'b1, 8'h96};
      16'h2014: r = {1'b1, 8'h97};
      16'h02DC: r = {1'b1, 8'h98};
      16'h2122: r = {1'b1, 8'h99};
      16'h0161: r = {1'b1, 8'h9A};
      16'h203A: r = {1'b1, 8'h9B};
      16'h0153: r = {1'b1, 8'h9C};
      16'h017E: r = {1'b1, 8'h9E};
      16'h0178: r = {1'b1, 8'h9F};
      default:  r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

/* hdl/u2c_front.sv */
// Front end: UTF-8 sequence assembly, code point encoding and output limit accounting.
`timescale 1ns / 1ps
module u2c_front import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  input  logic [7:0] esc_base,
  input  logic [15:0] out_limit,
  input  logic       q_full,
  output logic       q_push,
  output u2c_desc_t  q_desc
);

  logic [15:0] pc_r, pc_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic        four_r, four_nxt;
  logic [15:0] count_r, count_nxt;
  logic        stopped_r, stopped_nxt;

  logic        take;
  logic        cont;
  logic [15:0] pc_shift;
  logic [15:0] enc_cp;
  logic [15:0] v;
  logic [8:0]  spec;
  logic [7:0]  hi, lo;
  logic        eh, el;
  logic [2:0]  enc_k;
  logic [7:0]  enc_b0, enc_b1, enc_b2;
  logic [4:0]  fit;
  logic [2:0]  u_k;
  logic        u_each;
  logic [7:0]  u_b0, u_b1, u_b2;
  logic [2:0]  cnt;
  logic        term;

  assign take     = push && !q_full;
  assign cont     = (need_r != 2'd0);
  assign pc_shift = {pc_r[9:0], in_byte[5:0]};
  assign enc_cp   = cont ? pc_shift : {8'h00, in_byte};

  // encode one code point: plain byte, cp1252 special, or three-byte escape
  always_comb begin
    spec = special_map(enc_cp);
    v    = (enc_cp > PUA_LO && enc_cp < PUA_HI) ? enc_cp + PUA_OFFSET : enc_cp;
    hi   = v[15:8];
    lo   = v[7:0];
    eh   = is_esc(hi);
    el   = is_esc(lo);
    if (enc_cp[15:8] == 8'h00) begin
      enc_k  = 3'd1;
      enc_b0 = enc_cp[7:0];
      enc_b1 = QMARK;
      enc_b2 = QMARK;
    end else if (spec[8]) begin
      enc_k  = 3'd1;
      enc_b0 = spec[7:0];
      enc_b1 = QMARK;
      enc_b2 = QMARK;
    end else begin
      enc_k  = 3'd3;
      enc_b0 = esc_base + {6'd0, eh, el};
      enc_b1 = el ? lo + LOW_ADJ : lo;
      enc_b2 = eh ? hi - HIGH_ADJ : hi;
    end
  end

  // room for k more bytes, k = 0..4
  always_comb begin
    fit[0] = 1'b1;
    for (int i = 1; i < 5; i++) begin
      fit[i] = !stopped_r && (({1'b0, count_r} + 17'(i)) < {1'b0, out_limit});
    end
  end

  always_comb begin
    pc_nxt      = pc_r;
    need_nxt    = need_r;
    taken_nxt   = taken_r;
    four_nxt    = four_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    u_k         = 3'd0;
    u_each      = 1'b0;
    u_b0        = QMARK;
    u_b1        = QMARK;
    u_b2        = QMARK;
    cnt         = 3'd0;
    term        = 1'b0;

    if (take) begin
      if (cont) begin
        pc_nxt    = pc_shift;
        taken_nxt = taken_r + 2'd1;
        need_nxt  = need_r - 2'd1;
        if (need_r == 2'd1) begin
          if (four_r) begin
            u_k = 3'd4;
          end else begin
            u_k  = enc_k;
            u_b0 = enc_b0;
            u_b1 = enc_b1;
            u_b2 = enc_b2;
          end
          pc_nxt    = '0;
          taken_nxt = '0;
          four_nxt  = 1'b0;
        end else if (in_is_last) begin
          // cut short: one '?' per byte taken, each checked on its own
          u_k       = {1'b0, taken_r + 2'd1};
          u_each    = 1'b1;
          pc_nxt    = '0;
          need_nxt  = '0;
          taken_nxt = '0;
          four_nxt  = 1'b0;
        end
      end else if (!in_byte[7]) begin
        u_k  = enc_k;
        u_b0 = enc_b0;
        u_b1 = enc_b1;
        u_b2 = enc_b2;
      end else if (in_byte[7:6] == 2'b11) begin
        if (in_is_last) begin
          u_k = 3'd1;
        end else begin
          taken_nxt = 2'd1;
          if (!in_byte[5]) begin
            pc_nxt   = {11'd0, in_byte[4:0]};
            need_nxt = 2'd1;
          end else if (!in_byte[4]) begin
            pc_nxt   = {12'd0, in_byte[3:0]};
            need_nxt = 2'd2;
          end else begin
            pc_nxt   = '0;
            need_nxt = 2'd3;
            four_nxt = 1'b1;
          end
        end
      end else begin
        u_k = 3'd1;
      end

      if (u_each) begin
        if (u_k >= 3'd3 && fit[3])      cnt = 3'd3;
        else if (u_k >= 3'd2 && fit[2]) cnt = 3'd2;
        else if (u_k >= 3'd1 && fit[1]) cnt = 3'd1;
        else                            cnt = 3'd0;
        if (cnt != u_k) stopped_nxt = 1'b1;
      end else if (u_k != 3'd0) begin
        if (fit[u_k]) cnt = u_k;
        else          stopped_nxt = 1'b1;
      end
      count_nxt = count_r + {13'd0, cnt};

      if (in_is_last) begin
        term        = 1'b1;
        count_nxt   = '0;
        stopped_nxt = 1'b0;
        pc_nxt      = '0;
        need_nxt    = '0;
        taken_nxt   = '0;
        four_nxt    = 1'b0;
      end
    end
  end

  assign q_push      = take && (cnt != 3'd0 || term);
  assign q_desc.cnt  = cnt;
  assign q_desc.term = term;
  assign q_desc.b0   = u_b0;
  assign q_desc.b1   = u_b1;
  assign q_desc.b2   = u_b2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      need_r    <= '0;
      taken_r   <= '0;
      four_r    <= 1'b0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      need_r    <= need_nxt;
      taken_r   <= taken_nxt;
      four_r    <= four_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  a_four_open: assert property (@(posedge clk) disable iff (!rst_n)
    four_r |-> need_r != 2'd0)
    else $error("four-byte flag set with no sequence open");

  a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_is_last |=> count_r == '0 && !stopped_r && need_r == '0)
    else $error("string state not cleared after last byte");

endmodule

/* hdl/u2c_fifo.sv */
// Small register queue of unit descriptors between front and back end.
`timescale 1ns / 1ps
module u2c_fifo import u2c_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  u2c_desc_t din,
  output logic      full,
  input  logic      pop,
  output u2c_desc_t dout,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u2c_desc_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/u2c_back.sv */
// Back end: expands queued units into single output beats through an output register.
`timescale 1ns / 1ps
module u2c_back import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  u2c_desc_t  head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_string_end
);

  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       run_end_r, str_end_r;

  logic [2:0] total;
  logic       load;
  logic       last_beat;
  logic [7:0] cur_byte;

  assign total     = head.cnt + {2'd0, head.term};
  assign load      = (!valid_r || pop) && !q_empty;
  assign last_beat = (idx_r == total - 3'd1);
  assign q_pop     = load && last_beat;

  always_comb begin
    if (idx_r >= head.cnt) begin
      cur_byte = TERM_BYTE;
    end else begin
      case (idx_r)
        3'd0:    cur_byte = head.b0;
        3'd1:    cur_byte = head.b1;
        3'd2:    cur_byte = head.b2;
        default: cur_byte = QMARK;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (!valid_r || pop) valid_nxt = !q_empty;
    if (load) idx_nxt = last_beat ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= cur_byte;
      run_end_r <= last_beat;
      str_end_r <= head.term && (idx_r == head.cnt);
    end
  end

  assign empty          = !valid_r;
  assign out_byte       = byte_r;
  assign out_run_end    = run_end_r;
  assign out_string_end = str_end_r;

  a_term_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && str_end_r |-> run_end_r)
    else $error("terminator beat not marked as end of run");

  a_idx_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < total)
    else $error("beat index beyond current unit");

  a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 3'd0)
    else $error("beat index not rewound after unit");

endmodule

/* hdl/utf8_to_escaped_cp1252_encoder_unit.sv */
// Top level of the UTF-8 to escaped Windows-1252 encoder.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ---------------------------
//  input     in_byte[7:0], in_is_last                     push & !full
//  result    out_byte[7:0], out_run_end, out_string_end   pop & !empty
//  config    cfg_index, cfg_wdata[15:0]                   cfg_wr_en (0 escape_base, 1 out_limit)
//
// One input byte is taken per cycle while the queue is not full; its results are queued
// as a single unit. The back end emits one result beat per cycle while pop is high, and a
// byte with n results holds the output for n beats; the descriptor queue (FIFO_DEPTH units)
// absorbs bursts. The first result passes the queue and then the output register.
// Reset (rst_n low, synchronous) empties the queue and string state, escape_base=16,
// out_limit=32768.
`timescale 1ns / 1ps
module utf8_to_escaped_cp1252_encoder_unit import u2c_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 in_is_last,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 out_run_end,
  output logic                 out_string_end,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [7:0]  esc_base_r;
  logic [15:0] out_limit_r;

  logic        q_push, q_pop, q_full, q_empty;
  u2c_desc_t   q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_base_r  <= ESC_BASE_RST;
      out_limit_r <= OUT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ESCAPE_BASE: esc_base_r  <= cfg_wdata[7:0];
        REG_OUT_LIMIT:   out_limit_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign full = q_full;

  u2c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .esc_base   (esc_base_r),
    .out_limit  (out_limit_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_desc     (q_din)
  );

  u2c_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  u2c_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_dout),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule

/* tb/utf8_to_escaped_cp1252_encoder_unit_test.sv */
// Self-checking testbench for the UTF-8 to escaped Windows-1252 encoder unit.
`timescale 1ns / 1ps
module utf8_to_escaped_cp1252_encoder_unit_test;
  import u2c_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  n_typed;  // 0: take the results from the encoder model
    logic [39:0] typed;    // typed result bytes, first beat in the low byte
  } dir_row_t;

  localparam int ROW_COUNT     = 27;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD   = 20000;

  localparam dir_row_t DIR_ROWS [ROW_COUNT] = '{
    {8'h41, 1'b0, 3'd1, 40'h41},           // plain ASCII
    {8'h00, 1'b0, 3'd1, 40'h00},           // zero byte mid-string, no string end
    {8'h7F, 1'b0, 3'd1, 40'h7F},
    {8'h85, 1'b0, 3'd1, 40'h3F},           // stray continuation
    {8'hC3, 1'b0, 3'd0, 40'h0},
    {8'hA9, 1'b0, 3'd0, 40'h0},            // U+00E9
    {8'hE2, 1'b0, 3'd0, 40'h0},
    {8'h82, 1'b0, 3'd0, 40'h0},
    {8'hAC, 1'b0, 3'd1, 40'h80},           // euro sign, a CP1252 special
    {8'hC4, 1'b0, 3'd0, 40'h0},
    {8'h80, 1'b0, 3'd0, 40'h0},            // U+0100, low byte is an escape byte
    {8'hE2, 1'b0, 3'd0, 40'h0},
    {8'h90, 1'b0, 3'd0, 40'h0},
    {8'h80, 1'b0, 3'd0, 40'h0},            // U+2400, both bytes adjusted
    {8'hEF, 1'b0, 3'd0, 40'h0},
    {8'hBF, 1'b0, 3'd0, 40'h0},
    {8'hBF, 1'b0, 3'd3, 40'hFF_FF10},      // U+FFFF
    {8'hF0, 1'b0, 3'd0, 40'h0},
    {8'h9F, 1'b0, 3'd0, 40'h0},
    {8'h98, 1'b0, 3'd0, 40'h0},
    {8'h80, 1'b0, 3'd4, 40'h3F3F_3F3F},    // four-byte sequence
    {8'hE4, 1'b0, 3'd0, 40'h0},
    {8'hB8, 1'b1, 3'd3, 40'h00_3F3F},      // cut short by end of string
    {8'hFF, 1'b1, 3'd2, 40'h00_3F},        // lead on the last byte
    {8'hC2, 1'b0, 3'd0, 40'h0},
    {8'hFF, 1'b1, 3'd0, 40'h0},            // unchecked continuation closes it
    {8'hBF, 1'b1, 3'd2, 40'h00_3F}
  };

  localparam logic [15:0] SPECIAL_CP [27] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h02C6,
    16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018, 16'h2019, 16'h201C,
    16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A,
    16'h0153, 16'h017E, 16'h0178
  };
  localparam logic [7:0] SPECIAL_CODE [27] = '{
    8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
  };
  localparam logic [7:0] ESCAPE_SET [29] = '{
    8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
    8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'h5F, 8'hBD, 8'h3B,
    8'h5D, 8'h3D, 8'h23, 8'h3F, 8'h3A, 8'h3C, 8'h3E, 8'h2A, 8'h7C
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_byte = 8'h00;
  logic                 in_is_last = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_end;
  logic                 out_string_end;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ESCAPE_BASE;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // encoder model state
  logic [7:0]  esc_base = ESC_BASE_RST;
  logic [15:0] buf_limit = OUT_LIMIT_RST;
  logic [15:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  seq_len = '0;
  logic        seq_four = 1'b0;
  logic [15:0] str_len = '0;
  logic        str_halted = 1'b0;

  beat_t      cp1252_due[$];
  beat_t      step_beats[$];
  logic [7:0] str_bytes[$];
  int         fail_count = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  utf8_to_escaped_cp1252_encoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit note_fail();
    fail_count++;
    return fail_count <= 10;
  endfunction

  function automatic bit in_esc_set(logic [7:0] b);
    int i;
    for (i = 0; i < 29; i++)
      if (ESCAPE_SET[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void emit_beat(logic [7:0] b, logic se);
    beat_t bt;
    bt.data = b;
    bt.run_end = 1'b0;
    bt.str_end = se;
    step_beats.push_back(bt);
  endfunction

  // room for k more bytes below the limit, else the rest of the string is dropped
  function automatic bit reserve(int k);
    if (str_halted) return 1'b0;
    if (int'(str_len) + k >= int'(buf_limit)) begin
      str_halted = 1'b1;
      return 1'b0;
    end
    str_len = str_len + 16'(k);
    return 1'b1;
  endfunction

  function automatic void encode_cp(logic [15:0] cp);
    logic [15:0] v;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [1:0]  off;
    int          i;
    if (cp <= 16'h00FF) begin
      if (reserve(1)) emit_beat(cp[7:0], 1'b0);
      return;
    end
    for (i = 0; i < 27; i++) begin
      if (SPECIAL_CP[i] == cp) begin
        if (reserve(1)) emit_beat(SPECIAL_CODE[i], 1'b0);
        return;
      end
    end
    v = cp;
    if (v > PUA_LO && v < PUA_HI) v = v + PUA_OFFSET;
    hi = v[15:8];
    lo = v[7:0];
    if (!reserve(3)) return;
    off = {in_esc_set(hi), in_esc_set(lo)};
    if (off[0]) lo = lo + LOW_ADJ;
    if (off[1]) hi = hi - HIGH_ADJ;
    emit_beat(esc_base + 8'(off), 1'b0);
    emit_beat(lo, 1'b0);
    emit_beat(hi, 1'b0);
  endfunction

  function automatic void clear_seq();
    cp_acc = '0;
    cont_left = '0;
    seq_len = '0;
    seq_four = 1'b0;
  endfunction

  // results caused by one accepted input byte, left in step_beats
  function automatic void encode_utf8_byte(logic [7:0] b, logic l);
    int    k;
    beat_t bt;
    step_beats.delete();
    if (cont_left != 2'd0) begin
      cp_acc = {cp_acc[9:0], b[5:0]};
      seq_len = seq_len + 2'd1;
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (seq_four) begin
          if (reserve(4))
            for (k = 0; k < 4; k++) emit_beat(QMARK, 1'b0);
        end else begin
          encode_cp(cp_acc);
        end
        clear_seq();
      end else if (l) begin
        // one '?' per byte taken, each against the limit
        for (k = 0; k < int'(seq_len); k++)
          if (reserve(1)) emit_beat(QMARK, 1'b0);
        clear_seq();
      end
    end else if (b < 8'h80) begin
      encode_cp({8'h00, b});
    end else if (b >= 8'hC0) begin
      if (l) begin
        if (reserve(1)) emit_beat(QMARK, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        cp_acc = {11'd0, b[4:0]};
        cont_left = 2'd1;
        seq_len = 2'd1;
      end else if (b[7:4] == 4'hE) begin
        cp_acc = {12'd0, b[3:0]};
        cont_left = 2'd2;
        seq_len = 2'd1;
      end else begin
        cp_acc = '0;
        cont_left = 2'd3;
        seq_len = 2'd1;
        seq_four = 1'b1;
      end
    end else begin
      if (reserve(1)) emit_beat(QMARK, 1'b0);
    end
    if (l) begin
      emit_beat(TERM_BYTE, 1'b1);
      clear_seq();
      str_len = '0;
      str_halted = 1'b0;
    end
    if (step_beats.size() > 0) begin
      bt = step_beats.pop_back();
      bt.run_end = 1'b1;
      step_beats.push_back(bt);
    end
  endfunction

  task automatic put_byte(logic [7:0] b, logic l, logic [2:0] n_typed, logic [39:0] typed);
    int    gap;
    int    j;
    beat_t bt;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_is_last <= l;
    do @(posedge clk); while (full);
    encode_utf8_byte(b, l);
    if (n_typed != 3'd0) begin
      step_beats.delete();
      for (j = 0; j < int'(n_typed); j++) begin
        bt.data = typed[8*j +: 8];
        bt.run_end = (j == int'(n_typed) - 1);
        bt.str_end = l && bt.run_end;
        step_beats.push_back(bt);
      end
    end
    while (step_beats.size() > 0) cp1252_due.push_back(step_beats.pop_front());
  endtask

  function automatic logic [7:0] cont_byte(logic [5:0] bits);
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return {2'b10, bits};
  endfunction

  function automatic void put_cp(logic [15:0] cp);
    if (cp < 16'h0080) begin
      str_bytes.push_back(cp[7:0]);
    end else if (cp < 16'h0800) begin
      str_bytes.push_back({3'b110, cp[10:6]});
      str_bytes.push_back(cont_byte(cp[5:0]));
    end else begin
      str_bytes.push_back({4'b1110, cp[15:12]});
      str_bytes.push_back(cont_byte(cp[11:6]));
      str_bytes.push_back(cont_byte(cp[5:0]));
    end
  endfunction

  // mostly well-formed strings, with some stray bytes and broken sequences
  task automatic send_string(inout int sent);
    int chars;
    int kind;
    int i;
    int n;
    str_bytes.delete();
    chars = $urandom_range(1, 10);
    for (i = 0; i < chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        str_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 48) begin
        // two-byte form, overlong ones included
        str_bytes.push_back({3'b110, 5'($urandom)});
        str_bytes.push_back(cont_byte(6'($urandom)));
      end else if (kind < 70) begin
        put_cp(16'($urandom_range(16'h0800, 16'hFFFF)));
      end else if (kind < 80) begin
        put_cp(SPECIAL_CP[$urandom_range(0, 26)]);
      end else if (kind < 87) begin
        str_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        for (n = 0; n < 3; n++) str_bytes.push_back(cont_byte(6'($urandom)));
      end else if (kind < 94) begin
        str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        str_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
        n = $urandom_range(0, 2);
        repeat (n) str_bytes.push_back(cont_byte(6'($urandom)));
      end
    end
    for (i = 0; i < str_bytes.size(); i++)
      put_byte(str_bytes[i], i == str_bytes.size() - 1, 3'd0, 40'h0);
    sent = sent + str_bytes.size();
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (cp1252_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (cp1252_due.size() != 0) begin
      if (note_fail()) $display("%0d result beats never arrived", cp1252_due.size());
      cp1252_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] base, logic [15:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ESCAPE_BASE;
    cfg_wdata <= {8'($urandom), base};
    @(posedge clk);
    cfg_index <= REG_OUT_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    esc_base = base;
    buf_limit = limit;
  endtask

  task automatic run_phase(logic [7:0] base, logic [15:0] limit, bit quiet, bit squeeze);
    int sent;
    drain_results();
    set_config(base, limit);
    calm = quiet;
    hold_req = squeeze;
    sent = 0;
    while (sent < PHASE_ITEMS) send_string(sent);
    push <= 1'b0;
    calm = 1'b0;
  endtask

  initial begin : result_side
    int    stall;
    beat_t got;
    beat_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pop && !empty) begin
          got = {out_byte, out_run_end, out_string_end};
          if (cp1252_due.size() == 0) begin
            if (note_fail())
              $display("unexpected beat: byte %02h run_end %0b string_end %0b",
                       got.data, got.run_end, got.str_end);
          end else begin
            want = cp1252_due.pop_front();
            if (got !== want && note_fail())
              $display("beat mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       want.data, want.run_end, want.str_end,
                       got.data, got.run_end, got.str_end);
          end
          stall = pick_gap();
        end
        // long hold-off so the input side backs up
        if (hold_req) begin
          hold_req = 1'b0;
          stall = HOLD_CYCLES;
        end
        if (stall > 0) begin
          stall--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (r = 0; r < ROW_COUNT; r++)
      put_byte(DIR_ROWS[r].data, DIR_ROWS[r].last, DIR_ROWS[r].n_typed, DIR_ROWS[r].typed);
    push <= 1'b0;
    run_phase(8'd0, 16'd4, 1'b0, 1'b0);
    run_phase(8'd252, 16'hFFFF, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 252)), 16'($urandom_range(4, 24)), 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 252)), 16'd8, 1'b1, 1'b0);
    run_phase(8'($urandom_range(0, 252)), 16'($urandom_range(4, 65535)), 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 252)), 16'hFFFF, 1'b1, 1'b1);
    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
hdl/u2c_pkg.sv
hdl/u2c_front.sv
hdl/u2c_fifo.sv
hdl/u2c_back.sv
hdl/utf8_to_escaped_cp1252_encoder_unit.sv
tb/utf8_to_escaped_cp1252_encoder_unit_test.sv
